FILE: hw/rtl/vbrhp_pkg.sv
// ----------------------------------------------------------------------------
// VBR info header parser package
// Shared types, phase codes, magic words and helpers.
// ----------------------------------------------------------------------------
package vbrhp_pkg;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_FLAGS  = 3'd1;
    localparam logic [2:0] PH_FRAMES = 3'd2;
    localparam logic [2:0] PH_BYTES  = 3'd3;
    localparam logic [2:0] PH_TOC    = 3'd4;
    localparam logic [2:0] PH_SCALE  = 3'd5;
    localparam logic [2:0] PH_IDLE   = 3'd6;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    localparam logic [31:0] FLAG_FRAMES = 32'h0000_0001;
    localparam logic [31:0] FLAG_BYTES  = 32'h0000_0002;
    localparam logic [31:0] FLAG_TOC    = 32'h0000_0004;
    localparam logic [31:0] FLAG_SCALE  = 32'h0000_0008;

    localparam logic [31:0] MAGIC_XING = 32'h5869_6E67;
    localparam logic [31:0] MAGIC_INFO = 32'h496E_666F;

    localparam logic [6:0] WORD_BYTES = 7'd4;
    localparam logic [6:0] TOC_LEN    = 7'd100;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  index;
        logic [7:0]  value;
        logic        hkind;
        logic [31:0] flags;
        logic [31:0] frames;
        logic [31:0] bytes;
        logic [31:0] quality;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    // next flagged field after phase 'from', or idle when none is left
    function automatic logic [2:0] next_field(input logic [2:0] from,
                                              input logic [31:0] flags);
        logic [2:0] ph;
        ph = PH_IDLE;
        if (from < PH_SCALE && (flags & FLAG_SCALE) != 32'd0) ph = PH_SCALE;
        if (from < PH_TOC && (flags & FLAG_TOC) != 32'd0) ph = PH_TOC;
        if (from < PH_BYTES && (flags & FLAG_BYTES) != 32'd0) ph = PH_BYTES;
        if (from < PH_FRAMES && (flags & FLAG_FRAMES) != 32'd0) ph = PH_FRAMES;
        return ph;
    endfunction

endpackage

FILE: hw/rtl/vbrhp_if.sv
// ----------------------------------------------------------------------------
// VBR info header parser channels
// Input byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vbrhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vbrhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [6:0]  table_index;
    logic [7:0]  table_value;
    logic        header_kind;
    logic [31:0] flags_word;
    logic [31:0] frame_total;
    logic [31:0] byte_total;
    logic [31:0] quality_scale;
    logic        last_result;

    modport source (output valid, output result_kind, output table_index,
                    output table_value, output header_kind, output flags_word,
                    output frame_total, output byte_total, output quality_scale,
                    output last_result, input ready);
    modport sink (input valid, input result_kind, input table_index,
                  input table_value, input header_kind, input flags_word,
                  input frame_total, input byte_total, input quality_scale,
                  input last_result, output ready);
endinterface

FILE: hw/rtl/vbrhp_parser.sv
// ----------------------------------------------------------------------------
// VBR info header parser core
// Registers one input beat, parses it against the kept header state and
// produces up to two results for the result queue.
// ----------------------------------------------------------------------------
module vbrhp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_ready,
    input  logic               i_space,
    output vbrhp_pkg::t_push   o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [2:0]  r_phase, n_phase;
    logic [6:0]  r_count, n_count;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_flags, n_flags;
    logic        r_kind, n_kind;
    logic [31:0] r_frames, n_frames;
    logic [31:0] r_bytes, n_bytes;

    logic              fire;
    logic [31:0]       sh;
    logic [6:0]        cnt;
    logic [31:0]       quality;
    logic              done;
    logic              prim_v, sec_v;
    vbrhp_pkg::t_result prim, sec, done_res;

    assign fire    = r_in_valid & i_space;
    assign o_ready = ~r_in_valid | i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_shift  = r_shift;
        n_flags  = r_flags;
        n_kind   = r_kind;
        n_frames = r_frames;
        n_bytes  = r_bytes;
        sh       = {r_shift[23:0], r_in_byte};
        cnt      = r_count + 7'd1;
        quality  = '0;
        done     = 1'b0;
        prim_v   = 1'b0;
        sec_v    = 1'b0;
        prim     = '0;
        sec      = '0;
        done_res = '0;

        if (r_phase != vbrhp_pkg::PH_IDLE) begin
            n_shift = sh;
            n_count = cnt;
            case (r_phase)
                vbrhp_pkg::PH_MAGIC: begin
                    if (cnt == vbrhp_pkg::WORD_BYTES) begin
                        n_count = '0;
                        n_shift = '0;
                        if (sh == vbrhp_pkg::MAGIC_XING) begin
                            n_kind  = 1'b0;
                            n_phase = vbrhp_pkg::PH_FLAGS;
                        end else if (sh == vbrhp_pkg::MAGIC_INFO) begin
                            n_kind  = 1'b1;
                            n_phase = vbrhp_pkg::PH_FLAGS;
                        end else begin
                            n_flags   = '0;
                            prim_v    = 1'b1;
                            prim.kind = vbrhp_pkg::KIND_FAIL;
                            n_phase   = vbrhp_pkg::PH_IDLE;
                        end
                    end
                end
                vbrhp_pkg::PH_FLAGS, vbrhp_pkg::PH_FRAMES, vbrhp_pkg::PH_BYTES: begin
                    if (cnt == vbrhp_pkg::WORD_BYTES) begin
                        if (r_phase == vbrhp_pkg::PH_FLAGS) begin
                            n_flags = sh;
                        end else if (r_phase == vbrhp_pkg::PH_FRAMES) begin
                            n_frames = sh;
                        end else begin
                            n_bytes = sh;
                        end
                        n_count = '0;
                        n_shift = '0;
                        n_phase = vbrhp_pkg::next_field(r_phase, n_flags);
                        done    = (n_phase == vbrhp_pkg::PH_IDLE);
                    end
                end
                vbrhp_pkg::PH_TOC: begin
                    prim_v     = 1'b1;
                    prim.kind  = vbrhp_pkg::KIND_ENTRY;
                    prim.index = cnt - 7'd1;
                    prim.value = r_in_byte;
                    if (cnt >= vbrhp_pkg::TOC_LEN) begin
                        n_count = '0;
                        n_shift = '0;
                        n_phase = vbrhp_pkg::next_field(r_phase, r_flags);
                        done    = (n_phase == vbrhp_pkg::PH_IDLE);
                    end
                end
                vbrhp_pkg::PH_SCALE: begin
                    if (cnt == vbrhp_pkg::WORD_BYTES) begin
                        quality = sh;
                        done    = 1'b1;
                        n_phase = vbrhp_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = vbrhp_pkg::PH_IDLE;
                end
            endcase

            done_res.kind    = vbrhp_pkg::KIND_DONE;
            done_res.hkind   = n_kind;
            done_res.flags   = n_flags;
            done_res.frames  = n_frames;
            done_res.bytes   = n_bytes;
            done_res.quality = quality;
            if (done) begin
                if (prim_v) begin
                    sec_v = 1'b1;
                    sec   = done_res;
                end else begin
                    prim_v = 1'b1;
                    prim   = done_res;
                end
            end

            // stream ended before the header was complete
            if (r_in_last && n_phase != vbrhp_pkg::PH_IDLE) begin
                if (prim_v) begin
                    sec_v     = 1'b1;
                    sec       = '0;
                    sec.kind  = vbrhp_pkg::KIND_FAIL;
                end else begin
                    prim_v    = 1'b1;
                    prim      = '0;
                    prim.kind = vbrhp_pkg::KIND_FAIL;
                end
            end
        end

        if (r_in_last) begin
            n_phase  = vbrhp_pkg::PH_MAGIC;
            n_count  = '0;
            n_shift  = '0;
            n_flags  = '0;
            n_kind   = 1'b0;
            n_frames = '0;
            n_bytes  = '0;
        end

        if (sec_v) begin
            sec.last = 1'b1;
        end else begin
            prim.last = prim_v;
        end
    end

    always_comb begin
        o_push.r0  = prim;
        o_push.r1  = sec;
        o_push.cnt = fire ? {1'b0, prim_v} + {1'b0, sec_v} : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= vbrhp_pkg::PH_MAGIC;
            r_count  <= '0;
            r_shift  <= '0;
            r_flags  <= '0;
            r_kind   <= 1'b0;
            r_frames <= '0;
            r_bytes  <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_flags  <= n_flags;
            r_kind   <= n_kind;
            r_frames <= n_frames;
            r_bytes  <= n_bytes;
        end
    end

    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_phase == vbrhp_pkg::PH_MAGIC && r_flags == 32'd0))
        else $error("last beat did not re-arm the parser");

    a_pair_starts_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (o_push.r0.kind == vbrhp_pkg::KIND_ENTRY))
        else $error("two results without a leading seek entry");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase == vbrhp_pkg::PH_IDLE) |-> (o_push.cnt == 2'd0))
        else $error("result produced while waiting for the last beat");

endmodule

FILE: hw/rtl/vbrhp_queue.sv
// ----------------------------------------------------------------------------
// VBR info header parser result queue
// Four-entry result queue taking up to two results per cycle, one out.
// ----------------------------------------------------------------------------
module vbrhp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vbrhp_pkg::t_push   i_push,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output vbrhp_pkg::t_result o_res
);

    vbrhp_pkg::t_result r_mem [vbrhp_pkg::QDEPTH];

    logic [vbrhp_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [vbrhp_pkg::QCNT_W-1:0] r_count, n_count;
    logic                         pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid & i_ready;
    assign o_space = (r_count <= vbrhp_pkg::QCNT_W'(vbrhp_pkg::QDEPTH - 2));
    assign n_count = r_count + vbrhp_pkg::QCNT_W'(i_push.cnt)
                   - vbrhp_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + vbrhp_pkg::QPTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + vbrhp_pkg::QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + vbrhp_pkg::QPTR_W'(1)] <= i_push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |->
        ({1'b0, r_count} + 4'(i_push.cnt) <= 4'(vbrhp_pkg::QDEPTH)))
        else $error("result queue overflow");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_wr_ptr == r_rd_ptr + vbrhp_pkg::QPTR_W'(r_count)))
        else $error("queue pointers disagree with count");

endmodule

FILE: hw/rtl/vbr_info_header_parser_top.sv
// ----------------------------------------------------------------------------
// VBR info header parser top level
// Path: beats are registered, parsed, and their results written to the queue.
// Throughput: one byte beat per cycle; a beat with two results is absorbed by
// the four-entry result queue, which holds off input when under two slots free.
// Reset: synchronous; parser re-armed to await the magic, queue emptied.
// ----------------------------------------------------------------------------
module vbr_info_header_parser_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vbrhp_in_if.sink       i_in,
    vbrhp_out_if.source    o_out
);

    vbrhp_pkg::t_push   push;
    vbrhp_pkg::t_result res;
    logic               space;
    logic               ready;
    logic               valid;

    vbrhp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.data_byte),
        .i_last  (i_in.last_byte),
        .o_ready (ready),
        .i_space (space),
        .o_push  (push)
    );

    vbrhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign i_in.ready          = ready;
    assign o_out.valid         = valid;
    assign o_out.result_kind   = res.kind;
    assign o_out.table_index   = res.index;
    assign o_out.table_value   = res.value;
    assign o_out.header_kind   = res.hkind;
    assign o_out.flags_word    = res.flags;
    assign o_out.frame_total   = res.frames;
    assign o_out.byte_total    = res.bytes;
    assign o_out.quality_scale = res.quality;
    assign o_out.last_result   = res.last;

endmodule
